// ----- rtl/u7wp_pkg.sv -----
// shared types, codes and helper functions for the utf-8 to 7-bit word packer
package u7wp_pkg;

  localparam int unsigned CodeW = 7;
  localparam int unsigned WordW = 36;
  localparam int unsigned AccW  = 4 * CodeW;
  localparam int unsigned CpW   = 21;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LEAD = 2'd1,
    STAT_UNMAPPED = 2'd2
  } status_t;

  localparam logic [CodeW-1:0] CodeLf = 7'o012;
  localparam logic [CodeW-1:0] CodeCr = 7'o015;

  typedef struct packed {
    logic [WordW-1:0] word;
    status_t          status;
    logic             final_word;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [CodeW-1:0] code;
  } lookup_t;

  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [2:0]       held;
    logic             done;
    logic [WordW-1:0] word;
  } put_t;

  // code point to 7-bit code table
  function automatic lookup_t map_lookup(logic [CpW-1:0] cp);
    lookup_t r;
    r.hit  = 1'b1;
    r.code = '0;
    case (cp)
      21'o020623: r.code = 7'o001;
      21'o001661: r.code = 7'o002;
      21'o001662: r.code = 7'o003;
      21'o021047: r.code = 7'o004;
      21'o000254: r.code = 7'o005;
      21'o001665: r.code = 7'o006;
      21'o001700: r.code = 7'o007;
      21'o001673: r.code = 7'o010;
      21'o021036: r.code = 7'o016;
      21'o021002: r.code = 7'o017;
      21'o021202: r.code = 7'o020;
      21'o021203: r.code = 7'o021;
      21'o021051: r.code = 7'o022;
      21'o021052: r.code = 7'o023;
      21'o021000: r.code = 7'o024;
      21'o021003: r.code = 7'o025;
      21'o021227: r.code = 7'o026;
      21'o020624: r.code = 7'o027;
      21'o020622: r.code = 7'o031;
      21'o021140: r.code = 7'o033;
      21'o021144: r.code = 7'o034;
      21'o021145: r.code = 7'o035;
      21'o021141: r.code = 7'o036;
      21'o021050: r.code = 7'o037;
      21'o020621: r.code = 7'o136;
      21'o020620: r.code = 7'o137;
      default:    r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // ascii remap for the characters with a different 7-bit code
  function automatic logic [CodeW-1:0] ascii_code(logic [CodeW-1:0] b);
    logic [CodeW-1:0] c;
    c = b;
    case (b)
      7'o137:  c = 7'o030;
      7'o175:  c = 7'o176;
      7'o176:  c = 7'o032;
      default: c = b;
    endcase
    return c;
  endfunction

  // append one code, closing the word on the fifth
  function automatic put_t put_code(logic [AccW-1:0] acc, logic [2:0] held,
                                    logic [CodeW-1:0] code);
    put_t r;
    r.word = '0;
    if (held == 3'd4) begin
      r.done = 1'b1;
      r.word = {acc, code, 1'b0};
      r.acc  = '0;
      r.held = 3'd0;
    end else begin
      r.done = 1'b0;
      r.acc  = {acc[AccW-CodeW-1:0], code};
      r.held = held + 3'd1;
    end
    return r;
  endfunction

  // left-justify a partial word, padding with nul codes
  function automatic logic [WordW-1:0] pad_word(logic [AccW-1:0] acc, logic [2:0] held);
    logic [WordW-1:0] w;
    case (held)
      3'd1:    w = {acc[6:0],  28'b0, 1'b0};
      3'd2:    w = {acc[13:0], 21'b0, 1'b0};
      3'd3:    w = {acc[20:0], 14'b0, 1'b0};
      3'd4:    w = {acc[27:0], 7'b0,  1'b0};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/utf8_to_seven_bit_word_packer_unit.sv -----
// top level of the utf-8 to 7-bit code packer, five codes per 36-bit word
//
// usage:
//   input channel: in_byte / end_of_input with in_valid, in_stall. one byte
//   is taken per transfer; end_of_input = 1 flushes pending codes and the
//   byte is ignored.
//   output channel: packed_word / status / final_word with out_valid,
//   out_stall. a transfer yields zero or one word.
//   one input transfer per cycle is sustained while in_stall is low. a
//   completed word is registered into the output register or skid stage.
//   decode, table match and packing are one short combinational pass from
//   the state registers into the output register.
//   a skid stage holds one word while the receiver stalls with the output
//   register full; in_stall rises only while that skid stage is occupied.
//   an illegal lead byte or unmapped code point gives one word with a
//   nonzero status, after which every input transfer is taken and dropped
//   until reset.
//   reset (rst, synchronous) empties the packing state, both output slots
//   and clears the halt flag.
module utf8_to_seven_bit_word_packer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [35:0] packed_word,
  output logic [1:0]  status,
  output logic        final_word
);

  // packing state; a carried lf is held as a one-code accumulator
  logic [u7wp_pkg::AccW-1:0] acc, acc_next;
  logic [2:0]                held, held_next;
  logic [u7wp_pkg::CpW-1:0]  cp, cp_next;
  logic [1:0]                cont, cont_next;
  logic                      halted, halted_next;

  // output register and skid stage
  u7wp_pkg::result_t out_q, skid_q, res;
  logic              skid_valid;
  logic              res_valid;

  logic              in_fire;
  logic              out_free;

  u7wp_pkg::lookup_t        lk;
  u7wp_pkg::put_t           p1, p2;
  logic [u7wp_pkg::CpW-1:0] cp_flush;
  logic [u7wp_pkg::CpW-1:0] cp_cont;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign packed_word = out_q.word;
  assign status      = out_q.status;
  assign final_word  = out_q.final_word;

  // open sequence completed with zero bits at flush
  always_comb begin
    case (cont)
      2'd1:    cp_flush = {cp[14:0], 6'b0};
      2'd2:    cp_flush = {cp[8:0], 12'b0};
      2'd3:    cp_flush = {cp[2:0], 18'b0};
      default: cp_flush = cp;
    endcase
  end

  assign cp_cont = {cp[14:0], in_byte[5:0]};

  always_comb begin
    acc_next    = acc;
    held_next   = held;
    cp_next     = cp;
    cont_next   = cont;
    halted_next = halted;
    res_valid   = 1'b0;
    res         = '{word: '0, status: u7wp_pkg::STAT_OK, final_word: 1'b0};
    lk          = u7wp_pkg::map_lookup(end_of_input ? cp_flush : cp_cont);
    p1          = '0;
    p2          = '0;

    if (halted) begin
      // halted: transfers are dropped
    end else if (end_of_input) begin
      acc_next  = '0;
      held_next = 3'd0;
      cp_next   = '0;
      cont_next = 2'd0;
      if (cont != 2'd0) begin
        if (!lk.hit) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res.status  = u7wp_pkg::STAT_UNMAPPED;
        end else begin
          p1             = u7wp_pkg::put_code(acc, held, lk.code);
          res_valid      = 1'b1;
          res.final_word = 1'b1;
          res.word       = p1.done ? p1.word : u7wp_pkg::pad_word(p1.acc, p1.held);
        end
      end else if (held != 3'd0) begin
        res_valid      = 1'b1;
        res.final_word = 1'b1;
        res.word       = u7wp_pkg::pad_word(acc, held);
      end
    end else if (cont != 2'd0) begin
      // continuation byte: only the low six bits count
      cont_next = cont - 2'd1;
      if (cont == 2'd1) begin
        cp_next = '0;
        if (!lk.hit) begin
          acc_next    = '0;
          held_next   = 3'd0;
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res.status  = u7wp_pkg::STAT_UNMAPPED;
        end else begin
          p1        = u7wp_pkg::put_code(acc, held, lk.code);
          acc_next  = p1.acc;
          held_next = p1.held;
          res_valid = p1.done;
          res.word  = p1.word;
        end
      end else begin
        cp_next = cp_cont;
      end
    end else if (in_byte == {1'b0, u7wp_pkg::CodeLf}) begin
      // lf goes out as cr then lf
      p1 = u7wp_pkg::put_code(acc, held, u7wp_pkg::CodeCr);
      if (p1.done) begin
        acc_next  = {{(u7wp_pkg::AccW-u7wp_pkg::CodeW){1'b0}}, u7wp_pkg::CodeLf};
        held_next = 3'd1;
        res_valid = 1'b1;
        res.word  = p1.word;
      end else begin
        p2        = u7wp_pkg::put_code(p1.acc, p1.held, u7wp_pkg::CodeLf);
        acc_next  = p2.acc;
        held_next = p2.held;
        res_valid = p2.done;
        res.word  = p2.word;
      end
    end else if (!in_byte[7]) begin
      p1        = u7wp_pkg::put_code(acc, held, u7wp_pkg::ascii_code(in_byte[6:0]));
      acc_next  = p1.acc;
      held_next = p1.held;
      res_valid = p1.done;
      res.word  = p1.word;
    end else if (in_byte[7:5] == 3'b110) begin
      cp_next   = {16'b0, in_byte[4:0]};
      cont_next = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      cp_next   = {17'b0, in_byte[3:0]};
      cont_next = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      cp_next   = {18'b0, in_byte[2:0]};
      cont_next = 2'd3;
    end else begin
      // stray continuation or out-of-range lead byte
      acc_next    = '0;
      held_next   = 3'd0;
      cp_next     = '0;
      cont_next   = 2'd0;
      halted_next = 1'b1;
      res_valid   = 1'b1;
      res.status  = u7wp_pkg::STAT_BAD_LEAD;
    end
  end

  // state update on every accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      held   <= 3'd0;
      cp     <= '0;
      cont   <= 2'd0;
      halted <= 1'b0;
    end else if (in_fire) begin
      acc    <= acc_next;
      held   <= held_next;
      cp     <= cp_next;
      cont   <= cont_next;
      halted <= halted_next;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= res;
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// testbench for the utf-8 to 7-bit word packer: directed and random byte streams against a predictor
module tb;

  localparam int unsigned CycleLimit = 400000;

  // byte values with special handling in the text stream
  localparam logic [7:0] ByteLf         = 8'o012;
  localparam logic [7:0] ByteUnderscore = 8'o137;
  localparam logic [7:0] ByteRbrace     = 8'o175;
  localparam logic [7:0] ByteTilde      = 8'o176;

  // mapped code points and their codes, first entry in the top bits
  localparam logic [26*21-1:0] TableCps = {
    21'o020623, 21'o001661, 21'o001662, 21'o021047, 21'o000254, 21'o001665,
    21'o001700, 21'o001673, 21'o021036, 21'o021002, 21'o021202, 21'o021203,
    21'o021051, 21'o021052, 21'o021000, 21'o021003, 21'o021227, 21'o020624,
    21'o020622, 21'o021140, 21'o021144, 21'o021145, 21'o021141, 21'o021050,
    21'o020621, 21'o020620
  };
  localparam logic [26*7-1:0] TableCodes = {
    7'o001, 7'o002, 7'o003, 7'o004, 7'o005, 7'o006, 7'o007, 7'o010, 7'o016,
    7'o017, 7'o020, 7'o021, 7'o022, 7'o023, 7'o024, 7'o025, 7'o026, 7'o027,
    7'o031, 7'o033, 7'o034, 7'o035, 7'o036, 7'o037, 7'o136, 7'o137
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [35:0] packed_word;
  logic [1:0]  status;
  logic        final_word;

  // predicted packer state
  logic [34:0] acc_m;
  int          held_m;
  logic [6:0]  carry_m;
  bit          carry_v_m;
  logic [20:0] cp_m;
  int          cont_m;
  bit          halt_m;

  u7wp_pkg::result_t expected_words[$];
  int          mismatches = 0;
  int          transfers_sent = 0;
  bit          calm = 1'b0;
  int unsigned cycle_count;

  utf8_to_seven_bit_word_packer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_input(end_of_input),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_word (packed_word),
    .status      (status),
    .final_word  (final_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // table match, -1 when the code point has no 7-bit code
  function automatic int map_code(logic [20:0] p);
    for (int i = 0; i < 26; i++) begin
      if (TableCps[(25-i)*21 +: 21] == p) return int'(TableCodes[(25-i)*7 +: 7]);
    end
    return -1;
  endfunction

  function automatic void clear_packing();
    acc_m     = '0;
    held_m    = 0;
    carry_m   = '0;
    carry_v_m = 1'b0;
    cp_m      = '0;
    cont_m    = 0;
  endfunction

  // a code that spilled out of a full word opens the next one
  function automatic void fold_carry();
    if (carry_v_m) begin
      acc_m     = {28'b0, carry_m};
      held_m    = 1;
      carry_v_m = 1'b0;
      carry_m   = '0;
    end
  endfunction

  // append one code, true when it closes a word
  function automatic bit add_code(input logic [6:0] c, output logic [35:0] w);
    fold_carry();
    acc_m = {acc_m[27:0], c};
    held_m++;
    w = '0;
    if (held_m >= 5) begin
      w      = {acc_m, 1'b0};
      acc_m  = '0;
      held_m = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void expect_word(logic [35:0] w, u7wp_pkg::status_t s, logic f);
    u7wp_pkg::result_t r;
    r.word       = w;
    r.status     = s;
    r.final_word = f;
    expected_words.push_back(r);
  endfunction

  function automatic void halt_with(u7wp_pkg::status_t s);
    clear_packing();
    halt_m = 1'b1;
    expect_word('0, s, 1'b0);
  endfunction

  // advance the predicted state by one accepted transfer
  task automatic predict_word(input logic [7:0] b, input logic eoi);
    logic [35:0] w;
    logic [20:0] pt;
    logic [6:0]  c;
    int          code;
    if (halt_m) return;

    if (eoi) begin
      // an open sequence is completed with zero bits
      if (cont_m > 0) begin
        pt     = 21'(cp_m << (6 * cont_m));
        cont_m = 0;
        cp_m   = '0;
        code   = map_code(pt);
        if (code < 0) begin
          halt_with(u7wp_pkg::STAT_UNMAPPED);
          return;
        end
        if (add_code(7'(code), w)) begin
          clear_packing();
          expect_word(w, u7wp_pkg::STAT_OK, 1'b1);
          return;
        end
      end
      fold_carry();
      if (held_m == 0) begin
        clear_packing();
        return;
      end
      // pad with nul codes up to a full word
      while (!add_code(7'd0, w)) begin
      end
      clear_packing();
      expect_word(w, u7wp_pkg::STAT_OK, 1'b1);
      return;
    end

    // continuation bytes are not checked, only the low six bits count
    if (cont_m > 0) begin
      cp_m = {cp_m[14:0], b[5:0]};
      cont_m--;
      if (cont_m > 0) return;
      code = map_code(cp_m);
      cp_m = '0;
      if (code < 0) begin
        halt_with(u7wp_pkg::STAT_UNMAPPED);
        return;
      end
      if (add_code(7'(code), w)) expect_word(w, u7wp_pkg::STAT_OK, 1'b0);
      return;
    end

    if (b == ByteLf) begin
      // cr that closes a word pushes lf into the carry slot
      if (add_code(u7wp_pkg::CodeCr, w)) begin
        carry_m   = u7wp_pkg::CodeLf;
        carry_v_m = 1'b1;
        expect_word(w, u7wp_pkg::STAT_OK, 1'b0);
        return;
      end
      if (add_code(u7wp_pkg::CodeLf, w)) expect_word(w, u7wp_pkg::STAT_OK, 1'b0);
      return;
    end

    if (b[7] == 1'b0) begin
      case (b)
        ByteUnderscore: c = 7'o030;
        ByteRbrace:     c = 7'o176;
        ByteTilde:      c = 7'o032;
        default:        c = b[6:0];
      endcase
      if (add_code(c, w)) expect_word(w, u7wp_pkg::STAT_OK, 1'b0);
      return;
    end

    if (b >= 8'o300 && b <= 8'o337) begin
      cp_m   = {16'b0, b[4:0]};
      cont_m = 1;
    end else if (b >= 8'o340 && b <= 8'o357) begin
      cp_m   = {17'b0, b[3:0]};
      cont_m = 2;
    end else if (b >= 8'o360 && b <= 8'o367) begin
      cp_m   = {18'b0, b[2:0]};
      cont_m = 3;
    end else begin
      halt_with(u7wp_pkg::STAT_BAD_LEAD);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(b, eoi);
    transfers_sent++;
  endtask

  // hold off the sender until every predicted word has been seen
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // continuation byte with random top bits
  function automatic logic [7:0] cont_byte(logic [5:0] bits);
    logic [1:0] top;
    top = 2'($urandom_range(3));
    return {top, bits};
  endfunction

  // encode a code point in 2, 3 or 4 bytes, overlong forms included
  task automatic send_code_point(input logic [20:0] p);
    int len;
    len = (p < 21'h800) ? $urandom_range(2, 4) : $urandom_range(3, 4);
    case (len)
      2: begin
        send_byte({3'b110, p[10:6]}, 1'b0);
      end
      3: begin
        send_byte({4'b1110, p[15:12]}, 1'b0);
        send_byte(cont_byte(p[11:6]), 1'b0);
      end
      default: begin
        send_byte({5'b11110, p[20:18]}, 1'b0);
        send_byte(cont_byte(p[17:12]), 1'b0);
        send_byte(cont_byte(p[11:6]), 1'b0);
      end
    endcase
    send_byte(cont_byte(p[5:0]), 1'b0);
  endtask

  // cut-off sequences whose zero-filled code point still maps
  task automatic send_partial_flush();
    case ($urandom_range(3))
      0: begin
        send_byte(8'he2, 1'b0);
        send_byte(cont_byte(6'h08), 1'b0);
      end
      1: send_byte(8'hcf, 1'b0);
      2: begin
        send_byte(8'he0, 1'b0);
        send_byte(cont_byte(6'h0f), 1'b0);
      end
      default: begin
        send_byte(8'hf0, 1'b0);
        send_byte(cont_byte(6'h02), 1'b0);
        send_byte(cont_byte(6'h08), 1'b0);
      end
    endcase
    send_byte(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ascii extremes, remapped characters, cr spill and flushes
  task automatic test_ascii_remap();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(ByteUnderscore, 1'b0);
    send_byte(ByteRbrace, 1'b0);
    send_byte(ByteTilde, 1'b0);
    // lf as the fifth code: cr closes the word, lf carries over
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(ByteLf, 1'b0);
    send_byte(8'hff, 1'b1);
    // nothing pending, no word
    send_byte(8'h00, 1'b1);
  endtask

  // 2-, 3- and 4-byte decode, unchecked continuation, flush inside a sequence
  task automatic test_multibyte_decode();
    send_byte(8'hc2, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h9e, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h80, 1'b0);
    // ascii bytes taken as continuations
    send_byte(8'he2, 1'b0);
    send_byte(8'h48, 1'b0);
    send_byte(8'h40, 1'b0);
    // cut short: the zero-filled code point becomes the fifth code
    send_byte(8'he2, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  // mostly well-formed text with random content, no halting input
  task automatic test_random_text(input int count);
    int start;
    int k;
    int pick;
    int idx;
    start = transfers_sent;
    while (transfers_sent - start < count) begin
      k    = transfers_sent - start;
      calm = (k >= 250 && k < 400);
      pick = $urandom_range(99);
      if (pick < 48) begin
        send_byte(8'($urandom_range(127)), 1'b0);
      end else if (pick < 56) begin
        send_byte(ByteLf, 1'b0);
      end else if (pick < 86) begin
        idx = $urandom_range(25);
        send_code_point(TableCps[(25-idx)*21 +: 21]);
      end else if (pick < 91) begin
        send_partial_flush();
      end else if (pick < 96) begin
        send_byte(8'($urandom), 1'b1);
      end else begin
        // control-byte noise
        send_byte(8'($urandom_range(31)), 1'b0);
      end
    end
    calm = 1'b0;
  endtask

  // one error of a random kind, then the block must stay silent
  task automatic test_error_halt();
    logic [20:0] p;
    repeat (3) send_byte(8'($urandom_range(32, 126)), 1'b0);
    case ($urandom_range(2))
      0: begin
        if ($urandom_range(1) == 1) send_byte(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
        else send_byte(8'($urandom_range(8'hf8, 8'hff)), 1'b0);
      end
      1: begin
        p = 21'($urandom_range(16'hffff));
        while (map_code(p) >= 0) p = 21'($urandom_range(16'hffff));
        send_code_point(p);
      end
      default: begin
        // zero-filled code point that is not in the table
        send_byte(8'hf0, 1'b0);
        send_byte(cont_byte(6'h02), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
    endcase
    repeat (20) send_byte(8'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // output check and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : out_check
    u7wp_pkg::result_t want;
    out_stall <= !calm && ($urandom_range(99) < 23);
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %09h status %0d final %0b",
                   packed_word, status, final_word);
      end else begin
        want = expected_words.pop_front();
        if (packed_word !== want.word || status !== want.status ||
            final_word !== want.final_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %09h/%0d/%0b actual %09h/%0d/%0b",
                     want.word, want.status, want.final_word,
                     packed_word, status, final_word);
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_byte      = '0;
    end_of_input = 1'b0;
    clear_packing();
    halt_m = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_ascii_remap();
    drain_words();
    test_multibyte_decode();
    drain_words();
    test_random_text(700);
    drain_words();
    test_error_halt();
    drain_words();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_words.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/u7wp_pkg.sv
rtl/utf8_to_seven_bit_word_packer_unit.sv
tb/sv/tb.sv
